@@ design/hc3_pkg.sv @@
// Shared types, constants, table builders and reduction helpers for the 3x3 Hill cipher block.
// No dependencies; every other file in this folder imports this package.
package hc3_pkg;

    // Field widths
    localparam int LET_W     = 5;   // one letter or one key entry
    localparam int KEY_W     = 45;  // nine key entries, row-major
    localparam int KEYS      = 9;
    localparam int N_W       = 6;   // holds the alphabet size itself (up to 32)
    localparam int ACC_W     = 12;  // widest sum of three letter products
    localparam int NCAP      = 32;  // every 5-bit value
    localparam int CFG_IDX_W = 1;

    localparam int DEF_ALPHABET_SIZE = 26;
    localparam int PROD_MAX          = (NCAP - 1) * (NCAP - 1);

    // Block queue depth (power of two)
    localparam int QDEPTH = 2;

    localparam logic [LET_W-1:0] PAD_LETTER = 5'd1;
    localparam logic [1:0]       ROW_LAST   = 2'd2;
    localparam logic [3:0]       K_LAST     = 4'd8;

    typedef logic [LET_W-1:0] t_letter;
    typedef logic [NCAP-1:0][LET_W-1:0] t_lut;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY  = 1'b0,
        CFG_MODE = 1'b1
    } t_cfg_idx;

    // One full block waiting for the matrix multiply
    typedef struct packed {
        logic              dec;
        t_letter [2:0]     ltr;
    } t_blk;

    // Key state seen by the multiply stage
    typedef struct packed {
        t_letter [KEYS-1:0] kred;   // key entries reduced into the alphabet
        t_letter [KEYS-1:0] kinv;   // inverse key, zero when not invertible
        logic               inv_ok;
    } t_keyset;

    // Inverse derivation sequencer
    typedef enum logic [1:0] {
        KI_IDLE,
        KI_ISSUE,
        KI_QUOT,
        KI_FIX
    } t_ki_state;

    typedef enum logic [1:0] {
        PH_COF,
        PH_DET,
        PH_INV
    } t_ki_phase;

    // Cofactor k = A*B - C*D, entries by row-major key index
    localparam logic [0:8][3:0] CF_A = {4'd4, 4'd5, 4'd3, 4'd7, 4'd8, 4'd6, 4'd1, 4'd2, 4'd0};
    localparam logic [0:8][3:0] CF_B = {4'd8, 4'd6, 4'd7, 4'd2, 4'd0, 4'd1, 4'd5, 4'd3, 4'd4};
    localparam logic [0:8][3:0] CF_C = {4'd5, 4'd3, 4'd4, 4'd8, 4'd6, 4'd7, 4'd2, 4'd0, 4'd1};
    localparam logic [0:8][3:0] CF_D = {4'd7, 4'd8, 4'd6, 4'd1, 4'd2, 4'd0, 4'd4, 4'd5, 4'd3};

    // Inverse entry k takes the transposed cofactor
    localparam logic [0:8][3:0] TRANSP = {4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

    // Build the table v mod n for every 5-bit v (elaboration only)
    function automatic t_lut build_mod_lut(input int n);
        t_lut lut;
        int   r;
        for (int v = 0; v < NCAP; v++) begin
            r = v;
            for (int s = 0; s < NCAP; s++) begin
                if (r >= n) r = r - n;
            end
            lut[v] = LET_W'(r);
        end
        return lut;
    endfunction

    // Build the table of inverses mod n, zero where none exists (elaboration only)
    function automatic t_lut build_inv_lut(input int n);
        t_lut lut;
        int   dd;
        int   acc;
        int   inv;
        for (int d = 0; d < NCAP; d++) begin
            dd = d;
            for (int s = 0; s < NCAP; s++) begin
                if (dd >= n) dd = dd - n;
            end
            acc = 0;
            inv = 0;
            for (int i = 1; i < NCAP; i++) begin
                if (i < n) begin
                    acc = acc + dd;
                    if (acc >= n) acc = acc - n;
                    if (acc == 1) inv = i;
                end
            end
            lut[d] = LET_W'(inv);
        end
        return lut;
    endfunction

    // Quotient estimate by reciprocal; low by at most one
    function automatic logic [ACC_W-1:0] red_quot(input logic [ACC_W-1:0] x,
                                                  input logic [ACC_W-1:0] recip);
        logic [2*ACC_W-1:0] p;
        p = x * recip;
        return p[2*ACC_W-1:ACC_W];
    endfunction

    // Remainder from the quotient estimate with one correction step
    function automatic t_letter red_fix(input logic [ACC_W-1:0] x,
                                        input logic [ACC_W-1:0] q,
                                        input logic [N_W-1:0]   n);
        logic [ACC_W-1:0] qn;
        logic [ACC_W-1:0] r;
        qn = q * ACC_W'(n);
        r  = x - qn;
        if (r >= ACC_W'(n)) r = r - ACC_W'(n);
        return r[LET_W-1:0];
    endfunction

endpackage

@@ design/hc3_fifo.sv @@
// Short block queue between the letter front end and the multiply back end.
// Depends on hc3_pkg for the block type and depth.
module hc3_fifo import hc3_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_blk i_wdata,
    input  logic i_pop,
    output t_blk o_rdata,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = $clog2(QDEPTH);

    t_blk               r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [PTR_W:0]     r_count;
    logic [PTR_W:0]     n_count;

    assign o_rdata = r_mem[r_rp];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_W+1)'(QDEPTH));

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_count <= n_count;
        end
    end

    // Store blocks
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_wdata;
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("block pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("block popped from an empty queue");

endmodule

@@ design/hc3_front.sv @@
// Letter front end: gathers letters into blocks of three, pads or drops at end of message.
// Depends on hc3_pkg for the block type and the reduction table builder.
module hc3_front import hc3_pkg::*; #(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_letter i_letter,
    input  logic    i_end_of_message,
    input  logic    i_mode_wr,
    input  logic    i_mode_data,
    input  logic    i_busy,
    input  logic    i_q_full,
    output logic    o_push,
    output t_blk    o_blk
);

    localparam t_lut MOD_LUT = build_mod_lut(ALPHABET_SIZE);

    logic          r_mode;
    logic [1:0]    r_fill;
    logic [1:0]    n_fill;
    t_letter [1:0] r_pend;
    logic          pend_wr;
    logic          accept;
    t_letter       lred;

    assign o_in_stall = i_q_full || i_busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign lred       = MOD_LUT[i_letter];

    // Classify the beat: complete a block, close a partial one, or hold it
    always_comb begin
        o_push     = 1'b0;
        o_blk.dec  = r_mode;
        o_blk.ltr  = {PAD_LETTER, PAD_LETTER, PAD_LETTER};
        n_fill     = r_fill;
        pend_wr    = 1'b0;
        if (accept) begin
            case (r_fill)
                2'd0: begin
                    o_blk.ltr[0] = lred;
                    if (i_end_of_message) begin
                        o_push = !r_mode;
                        n_fill = 2'd0;
                    end else begin
                        pend_wr = 1'b1;
                        n_fill  = 2'd1;
                    end
                end
                2'd1: begin
                    o_blk.ltr[0] = r_pend[0];
                    o_blk.ltr[1] = lred;
                    if (i_end_of_message) begin
                        o_push = !r_mode;
                        n_fill = 2'd0;
                    end else begin
                        pend_wr = 1'b1;
                        n_fill  = 2'd2;
                    end
                end
                2'd2: begin
                    o_blk.ltr[0] = r_pend[0];
                    o_blk.ltr[1] = r_pend[1];
                    o_blk.ltr[2] = lred;
                    o_push       = 1'b1;
                    n_fill       = 2'd0;
                end
                default: begin
                    n_fill = 2'd0;
                end
            endcase
        end
    end

    // Hold mode and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_mode_wr) r_mode <= i_mode_data;
            r_fill <= n_fill;
        end
    end

    // Buffer pending letters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (pend_wr) begin
            r_pend[r_fill[0]] <= lred;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("letter fill count out of range");

endmodule

@@ design/hc3_keyinv.sv @@
// Key register and inverse-key derivation over a shared multi-cycle mod-N reduction unit.
// Depends on hc3_pkg for the key set type, sequencer enums and reduction helpers.
module hc3_keyinv import hc3_pkg::*; #(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_key_wr,
    input  logic [KEY_W-1:0] i_key_data,
    output t_keyset          o_keyset,
    output logic             o_busy
);

    localparam t_lut             MOD_LUT = build_mod_lut(ALPHABET_SIZE);
    localparam t_lut             INV_LUT = build_inv_lut(ALPHABET_SIZE);
    localparam logic [ACC_W-1:0] RECIP   = ACC_W'((1 << ACC_W) / ALPHABET_SIZE);
    localparam logic [N_W-1:0]   NVAL    = N_W'(ALPHABET_SIZE);
    localparam logic [ACC_W-1:0] COF_OFS =
        ACC_W'(ALPHABET_SIZE * ((PROD_MAX + ALPHABET_SIZE - 1) / ALPHABET_SIZE));

    t_ki_state          r_state;
    t_ki_state          n_state;
    t_ki_phase          r_phase;
    logic [3:0]         r_k;
    t_keyset            r_kset;
    t_letter [KEYS-1:0] r_cof;
    t_letter            r_dinv;
    logic [ACC_W-1:0]   r_v;
    logic [ACC_W-1:0]   r_q;
    logic [ACC_W-1:0]   v;
    logic [ACC_W-1:0]   pa;
    logic [ACC_W-1:0]   pb;
    t_letter            res;
    logic               ld_v;
    logic               ld_q;
    logic               wr_res;

    assign o_keyset = r_kset;
    assign o_busy   = (r_state != KI_IDLE);
    assign res      = red_fix(r_v, r_q, NVAL);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KI_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: each step issues, estimates the quotient, then corrects
    always_comb begin
        n_state = r_state;
        ld_v    = 1'b0;
        ld_q    = 1'b0;
        wr_res  = 1'b0;
        case (r_state)
            KI_IDLE: begin
                if (i_key_wr) n_state = KI_ISSUE;
            end
            KI_ISSUE: begin
                ld_v    = 1'b1;
                n_state = KI_QUOT;
            end
            KI_QUOT: begin
                ld_q    = 1'b1;
                n_state = KI_FIX;
            end
            KI_FIX: begin
                wr_res = 1'b1;
                if (r_phase == PH_INV && r_k == K_LAST) n_state = KI_IDLE;
                else                                   n_state = KI_ISSUE;
            end
            default: begin
                n_state = KI_IDLE;
            end
        endcase
    end

    // Select the operand sum for the current step
    always_comb begin
        pa = ACC_W'(r_kset.kred[CF_A[r_k]]) * ACC_W'(r_kset.kred[CF_B[r_k]]);
        pb = ACC_W'(r_kset.kred[CF_C[r_k]]) * ACC_W'(r_kset.kred[CF_D[r_k]]);
        case (r_phase)
            PH_COF: v = pa + COF_OFS - pb;
            PH_DET: v = ACC_W'(r_kset.kred[0]) * ACC_W'(r_cof[0])
                      + ACC_W'(r_kset.kred[1]) * ACC_W'(r_cof[1])
                      + ACC_W'(r_kset.kred[2]) * ACC_W'(r_cof[2]);
            PH_INV: v = ACC_W'(r_cof[TRANSP[r_k]]) * ACC_W'(r_dinv);
            default: v = '0;
        endcase
    end

    // Reduction pipeline registers
    always_ff @(posedge i_clk) begin
        if (ld_v) r_v <= v;
        if (ld_q) r_q <= red_quot(r_v, RECIP);
    end

    // Step sequencing and key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COF;
            r_k     <= '0;
            r_kset  <= '0;
        end else if (i_key_wr) begin
            r_phase <= PH_COF;
            r_k     <= '0;
            for (int k = 0; k < KEYS; k++) begin
                r_kset.kred[k] <= MOD_LUT[i_key_data[LET_W*k +: LET_W]];
            end
        end else if (wr_res) begin
            case (r_phase)
                PH_COF: begin
                    if (r_k == K_LAST) begin
                        r_phase <= PH_DET;
                        r_k     <= '0;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                PH_DET: begin
                    r_kset.inv_ok <= (INV_LUT[res] != '0);
                    r_phase       <= PH_INV;
                end
                PH_INV: begin
                    r_kset.kinv[r_k] <= res;
                    if (r_k == K_LAST) r_k <= '0;
                    else               r_k <= r_k + 4'd1;
                end
                default: begin
                    r_phase <= PH_COF;
                end
            endcase
        end
    end

    // Cofactors and determinant inverse
    always_ff @(posedge i_clk) begin
        if (wr_res && r_phase == PH_COF) r_cof[r_k] <= res;
        if (wr_res && r_phase == PH_DET) r_dinv <= INV_LUT[res];
    end

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == KI_IDLE && !r_kset.inv_ok) |-> (r_kset.kinv == '0))
        else $error("inverse key not zero for a singular key");

endmodule

@@ design/hc3_back.sv @@
// Multiply back end: one result row per cycle unless stalled; three-stage mod-N pipe ending in the output register.
// Depends on hc3_pkg for the block and key set types and reduction helpers.
module hc3_back import hc3_pkg::*; #(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_blk    i_head,
    input  logic    i_empty,
    output logic    o_pop,
    input  t_keyset i_keyset,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_letter o_out_letter,
    output logic    o_last_of_block,
    output logic    o_key_not_invertible
);

    localparam logic [ACC_W-1:0] RECIP = ACC_W'((1 << ACC_W) / ALPHABET_SIZE);
    localparam logic [N_W-1:0]   NVAL  = N_W'(ALPHABET_SIZE);

    logic             en;
    logic             issue;
    logic [1:0]       r_row;
    logic [3:0]       row_base;
    t_letter [2:0]    m;
    logic [ACC_W-1:0] acc;

    logic             r_s1_v;
    logic [ACC_W-1:0] r_s1_acc;
    logic             r_s1_last;
    logic             r_s1_flag;
    logic             r_s2_v;
    logic [ACC_W-1:0] r_s2_acc;
    logic [ACC_W-1:0] r_s2_q;
    logic             r_s2_last;
    logic             r_s2_flag;
    logic             r_o_valid;
    t_letter          r_o_letter;
    logic             r_o_last;
    logic             r_o_flag;

    // Advance the whole pipe unless the output beat is stalled
    assign en    = !r_o_valid || !i_out_stall;
    assign issue = en && !i_empty;
    assign o_pop = issue && (r_row == ROW_LAST);

    // Row dot product against the key or its inverse
    always_comb begin
        row_base = 4'({r_row, 1'b0}) + 4'(r_row);
        for (int c = 0; c < 3; c++) begin
            if (i_head.dec) m[c] = i_keyset.kinv[row_base + 4'(c)];
            else            m[c] = i_keyset.kred[row_base + 4'(c)];
        end
        acc = ACC_W'(m[0]) * ACC_W'(i_head.ltr[0])
            + ACC_W'(m[1]) * ACC_W'(i_head.ltr[1])
            + ACC_W'(m[2]) * ACC_W'(i_head.ltr[2]);
    end

    // Valid bits and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= 2'd0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            if (issue) r_row <= (r_row == ROW_LAST) ? 2'd0 : r_row + 2'd1;
            r_s1_v    <= issue;
            r_s2_v    <= r_s1_v;
            r_o_valid <= r_s2_v;
        end
    end

    // Payload stages: sum, quotient estimate, corrected remainder
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_acc   <= acc;
            r_s1_last  <= (r_row == ROW_LAST);
            r_s1_flag  <= i_head.dec && !i_keyset.inv_ok;
            r_s2_acc   <= r_s1_acc;
            r_s2_q     <= red_quot(r_s1_acc, RECIP);
            r_s2_last  <= r_s1_last;
            r_s2_flag  <= r_s1_flag;
            r_o_letter <= red_fix(r_s2_acc, r_s2_q, NVAL);
            r_o_last   <= r_s2_last;
            r_o_flag   <= r_s2_flag;
        end
    end

    assign o_out_valid          = r_o_valid;
    assign o_out_letter         = r_o_letter;
    assign o_last_of_block      = r_o_last;
    assign o_key_not_invertible = r_o_flag;

    a_pop_on_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_row == 2'd0))
        else $error("row counter not restarted after block pop");

endmodule

@@ design/hill_cipher_3x3_mod26_top.sv @@
// Top level of the 3x3 Hill cipher stream block: letter front end, block queue,
// inverse-key unit and multiply back end. Depends on hc3_pkg and the hc3_* modules.
//
// Letters stream in at one per cycle unless stalled; every third letter (or the end of a
// message, when encrypting a partial block padded with 1) queues a block, and the back end
// emits its three result letters in order, so the sustained rate is one letter per cycle in
// and out when nothing stalls. A block's last letter is written into the queue, then each
// row passes the dot-product, quotient-estimate and remainder registers before its result
// letter is valid. Writing the key register starts the inverse derivation: 19 reduction
// steps, each an issue, a quotient estimate and a correction, on one shared mod-N unit,
// during which input and configuration are stalled.
// Decrypt results carry a flag when the key has no inverse; their letters are then zero.
module hill_cipher_3x3_mod26_top import hc3_pkg::*; #(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [LET_W-1:0]     i_letter,
    input  logic                 i_end_of_message,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [LET_W-1:0]     o_out_letter,
    output logic                 o_last_of_block,
    output logic                 o_key_not_invertible,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KEY_W-1:0]     i_cfg_data
);

    logic    cfg_fire;
    logic    key_wr;
    logic    mode_wr;
    logic    busy;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;
    t_blk    push_blk;
    t_blk    head_blk;
    t_keyset keyset;

    // Decode configuration beats
    assign o_cfg_ready = !busy;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign key_wr      = cfg_fire && (i_cfg_index == CFG_KEY);
    assign mode_wr     = cfg_fire && (i_cfg_index == CFG_MODE);

    hc3_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_letter         (i_letter),
        .i_end_of_message (i_end_of_message),
        .i_mode_wr        (mode_wr),
        .i_mode_data      (i_cfg_data[0]),
        .i_busy           (busy),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_blk            (push_blk)
    );

    hc3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_blk),
        .i_pop   (pop),
        .o_rdata (head_blk),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    hc3_keyinv #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_keyinv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_wr   (key_wr),
        .i_key_data (i_cfg_data),
        .o_keyset   (keyset),
        .o_busy     (busy)
    );

    hc3_back #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_head               (head_blk),
        .i_empty              (q_empty),
        .o_pop                (pop),
        .i_keyset             (keyset),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_out_letter         (o_out_letter),
        .o_last_of_block      (o_last_of_block),
        .o_key_not_invertible (o_key_not_invertible)
    );

endmodule

@@ bench/hill_cipher_3x3_mod26_top_tb.sv @@
// Self-checking testbench for hill_cipher_3x3_mod26_top: a directed table, then random
// messages under four idle/stall mixes, checked against a behavioral cipher predictor.
// Depends on hc3_pkg and the design files only.
module hill_cipher_3x3_mod26_top_tb import hc3_pkg::*; ();

    localparam int unsigned ALPHA       = DEF_ALPHABET_SIZE;
    localparam int          SETTLE      = 8;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          SHOWN_MAX   = 10;

    typedef enum logic [1:0] {
        RK_LETTER,
        RK_KEY,
        RK_MODE
    } t_row_kind;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        t_row_kind        kind;
        logic [KEY_W-1:0] arg;
        logic             eom;
        bit               typed;
        t_letter          want[3];
        logic             want_flag;
    } t_row;

    // One result beat
    typedef struct packed {
        t_letter ltr;
        logic    last;
        logic    bad_key;
    } t_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [LET_W-1:0]     i_letter;
    logic                 i_end_of_message;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [LET_W-1:0]     o_out_letter;
    logic                 o_last_of_block;
    logic                 o_key_not_invertible;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [KEY_W-1:0]     i_cfg_data;

    // Predictor state
    logic [KEY_W-1:0] cur_key;
    logic             cur_decrypt;
    t_letter          held_letters[2];
    int unsigned      held_count;
    int unsigned      inv_key[9];
    logic             inv_key_ok;

    t_beat       due_letters[$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;

    hill_cipher_3x3_mod26_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_letter             (i_letter),
        .i_end_of_message     (i_end_of_message),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_out_letter         (o_out_letter),
        .o_last_of_block      (o_last_of_block),
        .o_key_not_invertible (o_key_not_invertible),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Key entry (r, c), indexes wrapping, reduced into the alphabet
    function automatic int unsigned key_entry_mod(input int unsigned r, input int unsigned c);
        logic [KEY_W-1:0] v;
        v = cur_key >> (LET_W * ((r % 3) * 3 + (c % 3)));
        return int'(v[LET_W-1:0]) % ALPHA;
    endfunction

    // Adjugate times inverse determinant; all zero when no inverse exists
    function automatic void derive_inverse_key();
        int unsigned cof[9];
        int unsigned det;
        int unsigned dinv;
        int unsigned p;
        int unsigned q;
        bit          ok;
        det  = 0;
        dinv = 0;
        ok   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p = key_entry_mod(i + 1, j + 1) * key_entry_mod(i + 2, j + 2);
                q = key_entry_mod(i + 1, j + 2) * key_entry_mod(i + 2, j + 1);
                cof[i*3+j] = (p % ALPHA + ALPHA - q % ALPHA) % ALPHA;
            end
        end
        for (int j = 0; j < 3; j++)
            det = (det + key_entry_mod(0, j) * cof[j]) % ALPHA;
        for (int i = 1; i < ALPHA; i++) begin
            if ((det * i) % ALPHA == 1) begin
                dinv = i;
                ok   = 1'b1;
            end
        end
        inv_key_ok = ok;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                inv_key[j*3+i] = ok ? (cof[i*3+j] * dinv) % ALPHA : 0;
    endfunction

    // Take one letter into the block buffer; return 1 when a block comes out
    function automatic bit absorb_letter(input t_letter l, input logic eom,
                                         output t_letter res[3]);
        int unsigned blk[3];
        int unsigned cnt;
        int unsigned acc;
        int unsigned m;
        cnt = held_count;
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
            blk[i] = 0;
        end
        for (int i = 0; i < cnt; i++)
            blk[i] = held_letters[i];
        blk[cnt] = l;
        cnt++;
        if (cnt < 3) begin
            if (!eom) begin
                held_letters[cnt-1] = l;
                held_count          = cnt;
                return 1'b0;
            end
            held_count = 0;
            if (cur_decrypt)
                return 1'b0;
            for (int i = cnt; i < 3; i++)
                blk[i] = PAD_LETTER;
        end else begin
            held_count = 0;
        end
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) begin
                m   = cur_decrypt ? inv_key[r*3+c] : key_entry_mod(r, c);
                acc = acc + m * (blk[c] % ALPHA);
            end
            res[r] = t_letter'(acc % ALPHA);
        end
        return 1'b1;
    endfunction

    function automatic t_row row_letter(input int unsigned l, input bit eom);
        t_row rw;
        rw.kind      = RK_LETTER;
        rw.arg       = KEY_W'(l);
        rw.eom       = eom;
        rw.typed     = 1'b0;
        rw.want[0]   = '0;
        rw.want[1]   = '0;
        rw.want[2]   = '0;
        rw.want_flag = 1'b0;
        return rw;
    endfunction

    // Letter that closes a block whose result is written out in the table
    function automatic t_row row_block(input int unsigned l, input bit eom,
                                       input int unsigned a, input int unsigned b,
                                       input int unsigned c, input bit flag);
        t_row rw;
        rw           = row_letter(l, eom);
        rw.typed     = 1'b1;
        rw.want[0]   = t_letter'(a);
        rw.want[1]   = t_letter'(b);
        rw.want[2]   = t_letter'(c);
        rw.want_flag = flag;
        return rw;
    endfunction

    function automatic t_row row_key(input logic [KEY_W-1:0] k);
        t_row rw;
        rw      = row_letter(0, 1'b0);
        rw.kind = RK_KEY;
        rw.arg  = k;
        return rw;
    endfunction

    function automatic t_row row_mode(input bit m);
        t_row rw;
        rw      = row_letter(0, 1'b0);
        rw.kind = RK_MODE;
        rw.arg  = KEY_W'(m);
        return rw;
    endfunction

    function automatic void note_mismatch(input string what, input t_beat want,
                                          input t_beat got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MAX)
            $display("mismatch (%s): expected letter %0d last %0b flag %0b, %s%0d%s%0b%s%0b",
                     what, want.ltr, want.last, want.bad_key,
                     "got letter ", got.ltr, " last ", got.last, " flag ", got.bad_key);
    endfunction

    // Send one letter beat, with random idle cycles ahead of it
    task automatic send_letter(input t_row rw);
        t_letter res[3];
        t_beat   bt;
        i_cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_letter         <= rw.arg[LET_W-1:0];
        i_end_of_message <= rw.eom;
        do @(posedge i_clk); while (o_in_stall);
        if (absorb_letter(rw.arg[LET_W-1:0], rw.eom, res)) begin
            for (int r = 0; r < 3; r++) begin
                bt.ltr      = rw.typed ? rw.want[r] : res[r];
                bt.last     = (r == 2);
                bt.bad_key  = rw.typed ? rw.want_flag : (cur_decrypt && !inv_key_ok);
                due_letters = {due_letters, bt};
            end
        end
    endtask

    // Hold off the sender until every due letter has come out, then let the pipe empty
    task automatic drain_results();
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (due_letters.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write one register; valid stays up for a following write
    task automatic write_reg(input t_cfg_idx idx, input logic [KEY_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_KEY) begin
            cur_key = data;
            derive_inverse_key();
        end else begin
            cur_decrypt = data[0];
        end
    endtask

    // Drive receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Check each result beat against the oldest due letter
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.ltr     = o_out_letter;
            got.last    = o_last_of_block;
            got.bad_key = o_key_not_invertible;
            if (due_letters.size() == 0) begin
                want = '0;
                note_mismatch("no beat due", want, got);
            end else begin
                want = due_letters.pop_front();
                if (got.ltr !== want.ltr || got.last !== want.last
                        || got.bad_key !== want.bad_key)
                    note_mismatch("wrong field", want, got);
            end
        end
    end

    // Watchdog: end the run after too long without any accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("hill_cipher_3x3_mod26_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_row             plan[$];
        logic [KEY_W-1:0] key_word;
        int unsigned      msg_len;
        t_letter          l;
        bit               eom;

        // Key constants list entry 8 first; GYBNQKURP maps ACT to POH
        plan = '{
            // reset key encrypts everything to zero
            row_letter(0, 0), row_letter(25, 0), row_block(31, 0, 0, 0, 0, 0),
            // reset key is not invertible
            row_mode(1),
            row_letter(5, 0), row_letter(10, 0), row_block(20, 0, 0, 0, 0, 1),
            // identity key; out-of-range letter wraps
            row_key({5'd1, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd1}),
            row_letter(31, 0), row_letter(0, 0), row_block(25, 0, 5, 0, 25, 0),
            // partial block padded with one on encrypt
            row_mode(0),
            row_block(7, 1, 7, 1, 1, 0),
            // end of message on a full block
            row_key({5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13, 5'd1, 5'd24, 5'd6}),
            row_letter(0, 0), row_letter(2, 0), row_block(19, 1, 15, 14, 7, 0),
            row_mode(1),
            row_letter(15, 0), row_letter(14, 0), row_block(7, 0, 0, 2, 19, 0),
            // mode change inside a block
            row_letter(1, 0), row_mode(0), row_letter(2, 0), row_letter(3, 0),
            // all-ones key: entries wrap to 5, determinant zero
            row_mode(1),
            row_key('1),
            row_letter(1, 0), row_letter(2, 0), row_block(3, 0, 0, 0, 0, 1),
            // row swap: determinant is negative before reduction
            row_key({5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd1, 5'd0}),
            row_letter(11, 0), row_letter(12, 0), row_letter(13, 0),
            // partial block dropped on decrypt
            row_letter(9, 1)
        };

        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_letter         <= '0;
        i_end_of_message <= 1'b0;
        i_out_stall      <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_KEY;
        i_cfg_data       <= '0;

        cur_key     = '0;
        cur_decrypt = 1'b0;
        held_count  = 0;
        derive_inverse_key();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[n]) begin
            case (plan[n].kind)
                RK_LETTER: begin
                    send_letter(plan[n]);
                end
                RK_KEY: begin
                    drain_results();
                    write_reg(CFG_KEY, plan[n].arg);
                end
                default: begin
                    drain_results();
                    write_reg(CFG_MODE, plan[n].arg);
                end
            endcase
        end

        // Random messages under each idle/stall mix
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_gap_pct   = 48;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 48;
                end
                default: begin
                    send_gap_pct   = 26;
                    recv_stall_pct = 26;
                end
            endcase
            for (int msg = 0; msg < 4; msg++) begin
                case ($urandom_range(0, 7))
                    0:       key_word = '0;
                    1:       key_word = '1;
                    default: key_word = KEY_W'({$urandom(), $urandom()});
                endcase
                drain_results();
                write_reg(CFG_KEY, key_word);
                write_reg(CFG_MODE, KEY_W'({$urandom(), $urandom()}));
                msg_len = $urandom_range(1, 24);
                for (int k = 0; k < msg_len; k++) begin
                    // mostly valid letters, some above the alphabet
                    l   = ($urandom_range(0, 3) == 0) ? t_letter'($urandom_range(0, 31))
                                                      : t_letter'($urandom_range(0, 25));
                    eom = (k == msg_len - 1) && ($urandom_range(0, 7) != 0);
                    send_letter(row_letter(l, eom));
                end
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("hill_cipher_3x3_mod26_top_tb: done, clean");
        else
            $display("hill_cipher_3x3_mod26_top_tb: done, errors");
        $finish;
    end

endmodule
